// File: sv/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// shared constants, codes and types for the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int MODE_W      = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 4;
  localparam int CNT_OUT_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 2'd0,
    MODE_REMOVE    = 2'd1,
    MODE_LOOKUP    = 2'd2,
    MODE_DROP_TAIL = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef logic [VALUE_BITS-1:0] entry_t;

  // per-cell view of the fill level
  typedef struct packed {
    logic occupied;
    logic tail_slot;
  } cell_ctl_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic append_en;
    logic remove_en;
  } list_cmd_t;

endpackage

// File: sv/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// one list slot: holds an entry, compares it with the key, passes the
// first-match chain on and takes its right neighbor's entry to close a gap
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                clk,
  input  olist_pkg::cell_ctl_t ctl,
  input  olist_pkg::list_cmd_t cmd,
  input  olist_pkg::entry_t    key,
  input  logic                found_in,
  input  olist_pkg::entry_t    next_entry,
  output olist_pkg::entry_t    entry,
  output logic                found_out,
  output logic                first
);
  import olist_pkg::*;

  logic match;

  assign match     = ctl.occupied && (entry == key);
  assign found_out = found_in || match;
  assign first     = match && !found_in;

  always_ff @(posedge clk) begin
    if (cmd.append_en && ctl.tail_slot) begin
      entry <= key;
    end else if (cmd.remove_en && found_out) begin
      entry <= next_entry;
    end
  end

endmodule

// File: sv/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// fixed-capacity list of signed words in insertion order, held in a row of
// shifting cells
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries mode and value: append, remove
// first match, look up first match, or drop the tail entry. Each transfer
// gives exactly one result on the output channel (out_valid/out_ready) with
// status, position and entry_count after the operation.
// Every cell compares its entry with the key at once; a first-match chain
// runs through the row and the matching cell and the cells past it take
// their neighbor's entry in the same cycle. The result is in the output
// register on the cycle after the transfer, and a new item is taken every
// cycle while the receiver keeps up.
// If the receiver stalls, the result holds and in_ready drops until it is
// taken; no list state changes meanwhile.
// Reset empties the list (count zero) and clears out_valid; entry contents
// are not cleared, since only entries below the count are ever compared.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [olist_pkg::MODE_W-1:0]  mode,
  input  logic signed [olist_pkg::IN_VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [olist_pkg::STATUS_W-1:0]  status,
  output logic [olist_pkg::POS_W-1:0]     position,
  output logic [olist_pkg::CNT_OUT_W-1:0] entry_count
);
  import olist_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  entry_t            key;
  list_cmd_t         cmd;
  cell_ctl_t         ctl   [CAPACITY];
  entry_t            entries [CAPACITY];
  logic [CAPACITY:0] found;
  logic [CAPACITY-1:0] first;
  logic [IDX_W-1:0]  match_idx;
  logic              any_match;
  status_t           status_next;
  logic [IDX_W-1:0]  pos_next;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign key       = entry_t'(value);
  assign found[0]  = 1'b0;
  assign any_match = found[CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].occupied  = CNT_W'(i) < count;
    assign ctl[i].tail_slot = CNT_W'(i) == count;

    if (i == CAPACITY - 1) begin : g_last
      olist_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .cmd        (cmd),
        .key        (key),
        .found_in   (found[i]),
        .next_entry (entries[i]),
        .entry      (entries[i]),
        .found_out  (found[i+1]),
        .first      (first[i])
      );
    end else begin : g_mid
      olist_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .cmd        (cmd),
        .key        (key),
        .found_in   (found[i]),
        .next_entry (entries[i+1]),
        .entry      (entries[i]),
        .found_out  (found[i+1]),
        .first      (first[i])
      );
    end
  end

  // one-hot first match to index
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd         = '0;
    status_next = ST_OK;
    pos_next    = '0;
    count_next  = count;
    unique case (mode_t'(mode))
      MODE_APPEND: begin
        if (count >= CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          cmd.append_en = accept;
          pos_next      = IDX_W'(count);
          count_next    = count + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (any_match) begin
          cmd.remove_en = accept;
          pos_next      = match_idx;
          count_next    = count - 1'b1;
        end else begin
          status_next = ST_MISSING;
        end
      end
      MODE_LOOKUP: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (any_match) begin
          pos_next = match_idx;
        end else begin
          status_next = ST_MISSING;
        end
      end
      MODE_DROP_TAIL: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      position    <= POS_W'(pos_next);
      entry_count <= CNT_OUT_W'(count_next);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_t'(mode) == MODE_APPEND && count < CNT_W'(CAPACITY))
    |=> count == $past(count) + 1'b1)
    else $error("append did not grow the list");

  a_lookup_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_t'(mode) == MODE_LOOKUP) |=> count == $past(count))
    else $error("lookup changed the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_t'(status) == ST_FULL)
    |-> entry_count == CNT_OUT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_t'(status) == ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with entries held");

endmodule

// File: verif/ordered_list_engine_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// self-checking bench for the ordered list engine
// ----------------------------------------------------------------------------
// Requests go in on the input channel and every one is run through a shadow
// copy of the list right when it transfers. The expected status, position and
// count wait in a queue and each result taken from the output channel is
// compared with the oldest of them. A short directed run covers the empty,
// full, duplicate and no-match cases. A long random run follows. It switches
// between filling and draining so that the list keeps reaching full and empty,
// and both sides of the bench stall at random except in its final stretch.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  localparam int RANDOM_ITEMS = 920;
  localparam int CALM_ITEMS   = 150;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [IN_VALUE_W-1:0] operand_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] entry_count;
  } list_reply_t;

  class list_scoreboard;
    entry_t      shadow_entries[CAPACITY];
    int unsigned shadow_count;
    list_reply_t pending_replies[$];
    int unsigned failures;
    int unsigned requests;
    int unsigned replies;
    int unsigned full_refusals;
    int unsigned empty_hits;

    function new();
      shadow_count  = 0;
      failures      = 0;
      requests      = 0;
      replies       = 0;
      full_refusals = 0;
      empty_hits    = 0;
    endfunction

    function void note_request(mode_t op, operand_t operand);
      entry_t      key;
      list_reply_t want;
      int          hit;
      key = entry_t'(operand);
      want.status = ST_OK;
      want.position = '0;
      hit = -1;
      requests++;
      for (int i = 0; i < int'(shadow_count); i++) begin
        if (hit < 0 && shadow_entries[i] == key) hit = i;
      end
      if (op == MODE_APPEND) begin
        if (shadow_count >= CAPACITY) begin
          want.status = ST_FULL;
          full_refusals++;
        end else begin
          shadow_entries[shadow_count] = key;
          want.position = POS_W'(shadow_count);
          shadow_count++;
        end
      end else if (shadow_count == 0) begin
        want.status = ST_EMPTY;
        empty_hits++;
      end else if (op == MODE_DROP_TAIL) begin
        shadow_count--;
      end else if (hit < 0) begin
        want.status = ST_MISSING;
      end else begin
        want.position = POS_W'(hit);
        if (op == MODE_REMOVE) begin
          for (int i = hit; i + 1 < int'(shadow_count); i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
        end
      end
      want.entry_count = CNT_OUT_W'(shadow_count);
      pending_replies.push_back(want);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
                              logic [CNT_OUT_W-1:0] cnt);
      list_reply_t want;
      replies++;
      if (pending_replies.size() == 0) begin
        $error("result with nothing expected: status %0d position %0d count %0d",
               st, pos, cnt);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        if (st !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, st);
          failures++;
        end
        if (pos !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, pos);
          failures++;
        end
        if (cnt !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
          failures++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [MODE_W-1:0]      mode = MODE_APPEND;
  operand_t               value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  logic [STATUS_W-1:0]    status;
  logic [POS_W-1:0]       position;
  logic [CNT_OUT_W-1:0]   entry_count;

  list_scoreboard sb = new();
  bit             idle_enable = 1'b1;
  bit             fill_phase = 1'b1;
  int unsigned    cycle_count = 0;

  ordered_list_engine uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_list_engine: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_reply(status, position, entry_count);
  end

  // result side stalls in bursts
  initial begin
    @(negedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(input mode_t op, input operand_t operand);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    value    <= operand;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, operand);
    @(negedge clk);
  endtask

  // mostly values held in the list, some corner values, some anything
  function automatic operand_t pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.shadow_count > 0 && roll < 60)
      return operand_t'(sb.shadow_entries[$urandom_range(0, sb.shadow_count - 1)]);
    if (roll < 80) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return '0;
        default: return operand_t'($urandom_range(1, 7));
      endcase
    end
    return $urandom;
  endfunction

  function automatic mode_t pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return mode_t'($urandom_range(0, 3));
    if (fill_phase) begin
      if (roll < 60) return MODE_APPEND;
      if (roll < 75) return MODE_REMOVE;
      if (roll < 90) return MODE_LOOKUP;
      return MODE_DROP_TAIL;
    end
    if (roll < 22) return MODE_APPEND;
    if (roll < 55) return MODE_REMOVE;
    if (roll < 75) return MODE_LOOKUP;
    return MODE_DROP_TAIL;
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list
    send_request(MODE_LOOKUP, 32'sd5);
    send_request(MODE_REMOVE, 32'sd5);
    send_request(MODE_DROP_TAIL, '0);
    // extremes and a duplicate
    send_request(MODE_APPEND, 32'h8000_0000);
    send_request(MODE_APPEND, 32'h7fff_ffff);
    send_request(MODE_APPEND, '0);
    send_request(MODE_APPEND, 32'hffff_ffff);
    send_request(MODE_APPEND, 32'h7fff_ffff);
    send_request(MODE_LOOKUP, 32'h7fff_ffff);
    send_request(MODE_REMOVE, 32'h7fff_ffff);
    send_request(MODE_LOOKUP, 32'h7fff_ffff);
    // no match
    send_request(MODE_LOOKUP, 32'sd5);
    send_request(MODE_REMOVE, 32'sd5);
    // head removal and tail drop
    send_request(MODE_REMOVE, 32'h8000_0000);
    send_request(MODE_DROP_TAIL, 32'hffff_ffff);
    // fill up, then refuse
    while (sb.shadow_count < CAPACITY) send_request(MODE_APPEND, $urandom);
    send_request(MODE_APPEND, 32'h1234_5678);
    send_request(MODE_LOOKUP, operand_t'(sb.shadow_entries[CAPACITY-1]));
    send_request(MODE_REMOVE, operand_t'(sb.shadow_entries[CAPACITY-1]));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending_replies.size() != 0);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_enable = 1'b0;
      if (sb.shadow_count == CAPACITY && $urandom_range(0, 3) == 0) fill_phase = 1'b0;
      else if (sb.shadow_count == 0 && $urandom_range(0, 3) == 0) fill_phase = 1'b1;
      send_request(pick_mode(), pick_operand());
    end

    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("%0d requests sent, %0d results checked", sb.requests, sb.replies);
    $display("%0d appends refused on a full list, %0d requests on an empty list",
             sb.full_refusals, sb.empty_hits);
    if (sb.failures == 0) begin
      $display("ordered_list_engine: match");
    end else begin
      $display("ordered_list_engine: mismatch");
    end
    $finish;
  end

endmodule
